// ----- rtl/core/msp_pkg.sv -----
package msp_pkg;

    localparam int NUM_W = 64;
    localparam int DEN_W = 84;
    localparam int QUO_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] KIND_MOTOR1 = 3'd0;
    localparam logic [2:0] KIND_MOTOR2 = 3'd1;
    localparam logic [2:0] KIND_DRIVE1 = 3'd2;
    localparam logic [2:0] KIND_DRIVE2 = 3'd3;
    localparam logic [2:0] KIND_CENTRE = 3'd4;
    localparam logic [2:0] KIND_ANGLE  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FALLBACK = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;

    localparam logic [2:0] REG_MOTOR1_MAX = 3'd0;
    localparam logic [2:0] REG_MOTOR2_MAX = 3'd1;
    localparam logic [2:0] REG_DRIVE1_SC  = 3'd2;
    localparam logic [2:0] REG_DRIVE2_SC  = 3'd3;
    localparam logic [2:0] REG_BASE_LEN   = 3'd4;
    localparam logic [2:0] REG_BASE_IN_MM = 3'd5;

    typedef struct packed {
        logic        mx1_neg;
        logic        mx2_neg;
        logic [31:0] mx1_mag;
        logic [31:0] mx2_mag;
        logic [31:0] sc1_mag;
        logic [31:0] sc2_mag;
        logic [31:0] base_mag;
        logic [4:0]  zero;
        logic        in_mm;
    } t_cfg;

    typedef struct packed {
        logic rej;
        logic fail;
        logic full;
    } t_flags;

    typedef struct packed {
        t_flags           flags;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_job;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] d1;
        logic [31:0] d2;
        logic [31:0] centre;
    } t_res;

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ----- rtl/core/msp_front.sv -----
module msp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [2:0]           i_kind,
    input  logic [31:0]          i_req,
    input  msp_pkg::t_cfg        i_cfg,
    output logic                 o_push,
    output msp_pkg::t_job        o_job
);
    localparam int DA_W = 72;

    logic              r_b_valid, r_c_valid, r_d_valid, r_e_valid;
    logic [2:0]        r_b_kind, r_c_kind, r_d_kind, r_e_kind;
    logic [31:0]       r_b_rmag, r_c_rmag, r_d_rmag, r_e_rmag;
    logic              r_b_neg, r_c_neg, r_d_neg, r_e_neg;
    logic              r_b_zero, r_c_zero, r_d_zero, r_e_zero;
    logic              r_b_rej, r_c_rej, r_d_rej, r_e_rej;
    logic [63:0]       r_c_p1, r_c_p2, r_c_pk, r_d_pk, r_e_pk;
    logic [DA_W-1:0]   r_d_da, r_d_db, r_e_da, r_e_db;
    logic [DA_W:0]     r_e_sum;
    logic              r_f_valid;
    msp_pkg::t_job     r_f_job, n_f_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
        r_b_kind <= i_kind;
        r_b_rmag <= msp_pkg::mag32(i_req);
        r_b_neg  <= i_req[31];
        r_b_zero <= (i_req == 32'd0);
        r_b_rej  <= (|i_cfg.zero) || (i_kind > msp_pkg::KIND_ANGLE);

        r_c_kind <= r_b_kind;
        r_c_rmag <= r_b_rmag;
        r_c_neg  <= r_b_neg;
        r_c_zero <= r_b_zero;
        r_c_rej  <= r_b_rej;
        r_c_p1   <= 64'(i_cfg.mx1_mag) * 64'(i_cfg.sc1_mag);
        r_c_p2   <= 64'(i_cfg.mx2_mag) * 64'(i_cfg.sc2_mag);
        r_c_pk   <= 64'(r_b_rmag) * 64'(i_cfg.base_mag);

        r_d_kind <= r_c_kind;
        r_d_rmag <= r_c_rmag;
        r_d_neg  <= r_c_neg;
        r_d_zero <= r_c_zero;
        r_d_rej  <= r_c_rej;
        r_d_pk   <= r_c_pk;
        r_d_da   <= DA_W'(r_c_p1) * DA_W'(1000);
        r_d_db   <= DA_W'(r_c_p2) * DA_W'(1000);

        r_e_kind <= r_d_kind;
        r_e_rmag <= r_d_rmag;
        r_e_neg  <= r_d_neg;
        r_e_zero <= r_d_zero;
        r_e_rej  <= r_d_rej;
        r_e_pk   <= r_d_pk;
        r_e_da   <= r_d_da;
        r_e_db   <= r_d_db;
        r_e_sum  <= (DA_W + 1)'(r_d_da) + (DA_W + 1)'(r_d_db);

        r_f_job  <= n_f_job;
    end

    always_comb begin
        n_f_job.flags.rej  = r_e_rej;
        n_f_job.flags.fail = (r_e_kind > msp_pkg::KIND_MOTOR2) && r_e_neg;
        n_f_job.flags.full = (r_e_kind > msp_pkg::KIND_MOTOR2) ? (r_e_neg || r_e_zero)
                                                               : r_e_zero;
        n_f_job.num = msp_pkg::NUM_W'(r_e_rmag);
        n_f_job.den = msp_pkg::DEN_W'(i_cfg.mx1_mag);
        unique case (r_e_kind)
            msp_pkg::KIND_MOTOR1: begin
                n_f_job.den = msp_pkg::DEN_W'(i_cfg.mx1_mag);
            end
            msp_pkg::KIND_MOTOR2: begin
                n_f_job.den = msp_pkg::DEN_W'(i_cfg.mx2_mag);
            end
            msp_pkg::KIND_DRIVE1: begin
                n_f_job.num = msp_pkg::NUM_W'(r_e_rmag) << FRAC_BITS;
                n_f_job.den = msp_pkg::DEN_W'(r_e_da);
            end
            msp_pkg::KIND_DRIVE2: begin
                n_f_job.num = msp_pkg::NUM_W'(r_e_rmag) << FRAC_BITS;
                n_f_job.den = msp_pkg::DEN_W'(r_e_db);
            end
            msp_pkg::KIND_CENTRE: begin
                n_f_job.num = msp_pkg::NUM_W'(r_e_rmag) << (FRAC_BITS + 1);
                n_f_job.den = msp_pkg::DEN_W'(r_e_sum);
            end
            msp_pkg::KIND_ANGLE: begin
                n_f_job.num = msp_pkg::NUM_W'(r_e_pk);
                n_f_job.den = i_cfg.in_mm ? msp_pkg::DEN_W'(r_e_sum) * msp_pkg::DEN_W'(1000)
                                          : msp_pkg::DEN_W'(r_e_sum);
            end
            default: begin
                n_f_job.num = msp_pkg::NUM_W'(r_e_rmag);
            end
        endcase
    end

    assign o_push = r_f_valid;
    assign o_job  = r_f_job;

endmodule

// ----- rtl/core/msp_queue.sv -----
module msp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  msp_pkg::t_job i_job,
    output logic          o_valid,
    output msp_pkg::t_job o_job,
    output logic          o_full
);
    localparam int PTR_W = $clog2(msp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(msp_pkg::QUEUE_DEPTH + 1);

    msp_pkg::t_job    r_mem [0:msp_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    // The back end never stalls, so the head is taken whenever it is present.
    assign pop     = (r_count != '0);
    assign o_valid = pop;
    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(msp_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(msp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(msp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/core/msp_back.sv -----
module msp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  msp_pkg::t_job i_job,
    input  msp_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output msp_pkg::t_res o_res,
    output logic [31:0]   o_angle
);
    localparam int QW   = msp_pkg::QUO_W;
    localparam int DW   = msp_pkg::DEN_W;
    localparam int TL_W = FRAC_BITS + 10;
    localparam int AN_W = 43 + FRAC_BITS;
    localparam int AH_W = AN_W - 32;

    // Fraction divider: one quotient bit per stage.
    logic              r_fd_valid [0:QW];
    msp_pkg::t_flags   r_fd_flags [0:QW];
    logic [DW-1:0]     r_fd_rem   [0:QW];
    logic [DW-1:0]     r_fd_den   [0:QW];
    logic [QW-1:0]     r_fd_q     [0:QW];
    logic [DW-1:0]     n_fd_rem   [1:QW];
    logic [QW-1:0]     n_fd_q     [1:QW];

    logic              r_m_valid, r_n_valid, r_o_valid, r_p_valid, r_s_valid;
    logic              r_t_valid, r_u_valid;
    logic [1:0]        r_m_status, r_n_status, r_o_status, r_p_status;
    logic [1:0]        r_s_status, r_t_status, r_u_status;
    logic [31:0]       r_m_m1, r_m_m2;
    logic [63:0]       r_n_p1, r_n_p2;
    logic [31:0]       r_n_m1s, r_n_m2s, r_o_m1s, r_o_m2s, r_p_m1s, r_p_m2s;
    logic [31:0]       r_s_m1s, r_s_m2s, r_t_m1s, r_t_m2s, r_u_m1s, r_u_m2s;
    logic              r_o_sat1, r_o_sat2;
    logic [31:0]       r_o_q1, r_o_q2;
    logic [9:0]        r_o_t1, r_o_t2;
    logic [31:0]       r_p_d1, r_p_d2, r_s_d1, r_s_d2, r_t_d1, r_t_d2, r_u_d1, r_u_d2;
    logic [32:0]       r_s_sum;
    logic [31:0]       r_t_centre, r_u_centre;
    logic [42:0]       r_t_fs;
    logic              r_u_sat;
    logic [31:0]       r_u_rem, r_u_low;

    // Angle divider.
    logic              r_ad_valid [0:QW];
    msp_pkg::t_res     r_ad_res   [0:QW];
    logic              r_ad_sat   [0:QW];
    logic [31:0]       r_ad_rem   [0:QW];
    logic [31:0]       r_ad_low   [0:QW];
    logic [QW-1:0]     r_ad_q     [0:QW];
    logic [31:0]       n_ad_rem   [1:QW];
    logic [QW-1:0]     n_ad_q     [1:QW];

    logic              r_out_valid;
    msp_pkg::t_res     r_out_res;
    logic [31:0]       r_out_angle;

    logic [32:0]       frac;
    logic [64:0]       mp1, mp2;
    logic [TL_W-1:0]   tl1, tl2;
    logic [41:0]       v1, v2;
    logic [AN_W-1:0]   an;
    logic [AH_W-1:0]   an_hi;

    always_comb begin
        logic [DW:0] sh;
        logic [32:0] ash;
        for (int i = 1; i <= QW; i++) begin
            sh = {r_fd_rem[i-1], 1'b0};
            if (sh >= {1'b0, r_fd_den[i-1]}) begin
                n_fd_rem[i] = DW'(sh - {1'b0, r_fd_den[i-1]});
                n_fd_q[i]   = {r_fd_q[i-1][QW-2:0], 1'b1};
            end else begin
                n_fd_rem[i] = DW'(sh);
                n_fd_q[i]   = {r_fd_q[i-1][QW-2:0], 1'b0};
            end
            ash = {r_ad_rem[i-1], r_ad_low[i-1][31]};
            if (ash >= {1'b0, i_cfg.base_mag}) begin
                n_ad_rem[i] = 32'(ash - {1'b0, i_cfg.base_mag});
                n_ad_q[i]   = {r_ad_q[i-1][QW-2:0], 1'b1};
            end else begin
                n_ad_rem[i] = 32'(ash);
                n_ad_q[i]   = {r_ad_q[i-1][QW-2:0], 1'b0};
            end
        end
    end

    assign frac  = r_fd_flags[QW].full ? {1'b1, 32'd0} : {1'b0, r_fd_q[QW]};
    assign mp1   = 65'(frac) * 65'(i_cfg.mx1_mag);
    assign mp2   = 65'(frac) * 65'(i_cfg.mx2_mag);
    assign tl1   = TL_W'(r_n_p1[FRAC_BITS-1:0]) * TL_W'(1000);
    assign tl2   = TL_W'(r_n_p2[FRAC_BITS-1:0]) * TL_W'(1000);
    assign v1    = 42'(r_o_q1) * 42'(1000) + 42'(r_o_t1);
    assign v2    = 42'(r_o_q2) * 42'(1000) + 42'(r_o_t2);
    assign an    = AN_W'(r_t_fs) << FRAC_BITS;
    assign an_hi = an[AN_W-1:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QW; i++) begin
                r_fd_valid[i] <= 1'b0;
                r_ad_valid[i] <= 1'b0;
            end
            r_m_valid   <= 1'b0;
            r_n_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_t_valid   <= 1'b0;
            r_u_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fd_valid[0] <= i_valid;
            for (int i = 1; i <= QW; i++) begin
                r_fd_valid[i] <= r_fd_valid[i-1];
            end
            r_m_valid     <= r_fd_valid[QW];
            r_n_valid     <= r_m_valid;
            r_o_valid     <= r_n_valid;
            r_p_valid     <= r_o_valid;
            r_s_valid     <= r_p_valid;
            r_t_valid     <= r_s_valid;
            r_u_valid     <= r_t_valid;
            r_ad_valid[0] <= r_u_valid;
            for (int i = 1; i <= QW; i++) begin
                r_ad_valid[i] <= r_ad_valid[i-1];
            end
            r_out_valid   <= r_ad_valid[QW];
        end

        r_fd_flags[0].rej  <= i_job.flags.rej;
        r_fd_flags[0].full <= i_job.flags.full
                              || (msp_pkg::DEN_W'(i_job.num) >= i_job.den);
        r_fd_flags[0].fail <= i_job.flags.fail
                              || (!i_job.flags.full && (msp_pkg::DEN_W'(i_job.num) > i_job.den));
        r_fd_rem[0] <= msp_pkg::DEN_W'(i_job.num);
        r_fd_den[0] <= i_job.den;
        r_fd_q[0]   <= '0;
        for (int i = 1; i <= QW; i++) begin
            r_fd_flags[i] <= r_fd_flags[i-1];
            r_fd_den[i]   <= r_fd_den[i-1];
            r_fd_rem[i]   <= n_fd_rem[i];
            r_fd_q[i]     <= n_fd_q[i];
        end

        r_m_status <= r_fd_flags[QW].rej  ? msp_pkg::ST_REJECT :
                      r_fd_flags[QW].fail ? msp_pkg::ST_FALLBACK : msp_pkg::ST_OK;
        r_m_m1 <= mp1[63:32];
        r_m_m2 <= mp2[63:32];

        r_n_status <= r_m_status;
        r_n_p1  <= 64'(r_m_m1) * 64'(i_cfg.sc1_mag);
        r_n_p2  <= 64'(r_m_m2) * 64'(i_cfg.sc2_mag);
        r_n_m1s <= i_cfg.mx1_neg ? (32'd0 - r_m_m1) : r_m_m1;
        r_n_m2s <= i_cfg.mx2_neg ? (32'd0 - r_m_m2) : r_m_m2;

        r_o_status <= r_n_status;
        r_o_m1s  <= r_n_m1s;
        r_o_m2s  <= r_n_m2s;
        r_o_sat1 <= |r_n_p1[63:FRAC_BITS+32];
        r_o_sat2 <= |r_n_p2[63:FRAC_BITS+32];
        r_o_q1   <= r_n_p1[FRAC_BITS+31:FRAC_BITS];
        r_o_q2   <= r_n_p2[FRAC_BITS+31:FRAC_BITS];
        r_o_t1   <= tl1[TL_W-1:FRAC_BITS];
        r_o_t2   <= tl2[TL_W-1:FRAC_BITS];

        r_p_status <= r_o_status;
        r_p_m1s <= r_o_m1s;
        r_p_m2s <= r_o_m2s;
        r_p_d1  <= (r_o_sat1 || (|v1[41:32])) ? 32'hFFFF_FFFF : v1[31:0];
        r_p_d2  <= (r_o_sat2 || (|v2[41:32])) ? 32'hFFFF_FFFF : v2[31:0];

        r_s_status <= r_p_status;
        r_s_m1s <= r_p_m1s;
        r_s_m2s <= r_p_m2s;
        r_s_d1  <= r_p_d1;
        r_s_d2  <= r_p_d2;
        r_s_sum <= 33'(r_p_d1) + 33'(r_p_d2);

        r_t_status <= r_s_status;
        r_t_m1s    <= r_s_m1s;
        r_t_m2s    <= r_s_m2s;
        r_t_d1     <= r_s_d1;
        r_t_d2     <= r_s_d2;
        r_t_centre <= r_s_sum[32:1];
        r_t_fs     <= i_cfg.in_mm ? 43'(r_s_sum) * 43'(1000) : 43'(r_s_sum);

        r_u_status <= r_t_status;
        r_u_m1s    <= r_t_m1s;
        r_u_m2s    <= r_t_m2s;
        r_u_d1     <= r_t_d1;
        r_u_d2     <= r_t_d2;
        r_u_centre <= r_t_centre;
        r_u_sat    <= (AN_W'(an_hi) >= AN_W'(i_cfg.base_mag));
        r_u_rem    <= 32'(an_hi);
        r_u_low    <= an[31:0];

        r_ad_res[0].status <= r_u_status;
        r_ad_res[0].m1     <= r_u_m1s;
        r_ad_res[0].m2     <= r_u_m2s;
        r_ad_res[0].d1     <= r_u_d1;
        r_ad_res[0].d2     <= r_u_d2;
        r_ad_res[0].centre <= r_u_centre;
        r_ad_sat[0] <= r_u_sat;
        r_ad_rem[0] <= r_u_rem;
        r_ad_low[0] <= r_u_low;
        r_ad_q[0]   <= '0;
        for (int i = 1; i <= QW; i++) begin
            r_ad_res[i] <= r_ad_res[i-1];
            r_ad_sat[i] <= r_ad_sat[i-1];
            r_ad_low[i] <= {r_ad_low[i-1][30:0], 1'b0};
            r_ad_rem[i] <= n_ad_rem[i];
            r_ad_q[i]   <= n_ad_q[i];
        end

        if (r_ad_res[QW].status == msp_pkg::ST_REJECT) begin
            r_out_res   <= msp_pkg::t_res'{status: msp_pkg::ST_REJECT, default: '0};
            r_out_angle <= '0;
        end else begin
            r_out_res   <= r_ad_res[QW];
            r_out_angle <= r_ad_sat[QW] ? 32'hFFFF_FFFF : r_ad_q[QW];
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;
    assign o_angle = r_out_angle;

endmodule

// ----- rtl/core/mirror_speed_propagation.sv -----
// Channel   Direction  Handshake              Payload
// request   in         i_start, o_busy        i_kind, i_requested_speed
// result    out        o_valid (strobe)       o_status, o_motor*_speed, o_drive*_speed,
//                                             o_centre_speed, o_angle_speed
// config    in         i_cfg_wr_en            i_cfg_index, i_cfg_wr_data
//
// One request is accepted per cycle while o_busy is low; its result strobe rises once the
// request has passed the front pipeline, the queue, the two 32-stage dividers (fraction and
// angle) and the multiplier stages, and the result is taken at the edge that ends the strobe.
// Reset is synchronous and active low; it clears all valid bits and restores the registers.
// The result strobe lasts one cycle and cannot be held off, so the pipeline never stalls.
module mirror_speed_propagation #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_requested_speed,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wr_data,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_motor1_speed,
    output logic signed [31:0] o_motor2_speed,
    output logic [31:0]        o_drive1_speed,
    output logic [31:0]        o_drive2_speed,
    output logic [31:0]        o_centre_speed,
    output logic [31:0]        o_angle_speed
);
    msp_pkg::t_cfg r_cfg;
    logic          front_push, q_valid, q_full;
    msp_pkg::t_job front_job, q_job;
    msp_pkg::t_res back_res;
    logic [31:0]   back_angle;
    logic [31:0]   wr_mag;

    assign wr_mag = msp_pkg::mag32(i_cfg_wr_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mx1_neg  <= 1'b0;
            r_cfg.mx2_neg  <= 1'b0;
            r_cfg.mx1_mag  <= 32'd1 << FRAC_BITS;
            r_cfg.mx2_mag  <= 32'd1 << FRAC_BITS;
            r_cfg.sc1_mag  <= 32'd1 << FRAC_BITS;
            r_cfg.sc2_mag  <= 32'd1 << FRAC_BITS;
            r_cfg.base_mag <= 32'd1 << FRAC_BITS;
            r_cfg.zero     <= '0;
            r_cfg.in_mm    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                msp_pkg::REG_MOTOR1_MAX: begin
                    r_cfg.mx1_neg <= i_cfg_wr_data[31];
                    r_cfg.mx1_mag <= wr_mag;
                    r_cfg.zero[0] <= (i_cfg_wr_data == 32'd0);
                end
                msp_pkg::REG_MOTOR2_MAX: begin
                    r_cfg.mx2_neg <= i_cfg_wr_data[31];
                    r_cfg.mx2_mag <= wr_mag;
                    r_cfg.zero[1] <= (i_cfg_wr_data == 32'd0);
                end
                msp_pkg::REG_DRIVE1_SC: begin
                    r_cfg.sc1_mag <= wr_mag;
                    r_cfg.zero[2] <= (i_cfg_wr_data == 32'd0);
                end
                msp_pkg::REG_DRIVE2_SC: begin
                    r_cfg.sc2_mag <= wr_mag;
                    r_cfg.zero[3] <= (i_cfg_wr_data == 32'd0);
                end
                msp_pkg::REG_BASE_LEN: begin
                    r_cfg.base_mag <= wr_mag;
                    r_cfg.zero[4]  <= (i_cfg_wr_data == 32'd0);
                end
                msp_pkg::REG_BASE_IN_MM: begin
                    r_cfg.in_mm <= i_cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    msp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_kind  (i_kind),
        .i_req   (i_requested_speed),
        .i_cfg   (r_cfg),
        .o_push  (front_push),
        .o_job   (front_job)
    );

    msp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    msp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_res   (back_res),
        .o_angle (back_angle)
    );

    assign o_busy         = q_full;
    assign o_status       = back_res.status;
    assign o_motor1_speed = back_res.m1;
    assign o_motor2_speed = back_res.m2;
    assign o_drive1_speed = back_res.d1;
    assign o_drive2_speed = back_res.d2;
    assign o_centre_speed = back_res.centre;
    assign o_angle_speed  = back_angle;

endmodule

// ----- bench/mirror_speed_propagation_test.sv -----
module mirror_speed_propagation_test;

    localparam int FRAC = 16;
    localparam logic [63:0] ONE_FRAC = 64'h1_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] d1;
        logic [31:0] d2;
        logic [31:0] centre;
        logic [31:0] angle;
    } t_speed_set;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [2:0]         i_kind = msp_pkg::KIND_MOTOR1;
    logic signed [31:0] i_requested_speed = '0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_index = msp_pkg::REG_MOTOR1_MAX;
    logic [31:0]        i_cfg_wr_data = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_motor1_speed;
    logic signed [31:0] o_motor2_speed;
    logic [31:0]        o_drive1_speed;
    logic [31:0]        o_drive2_speed;
    logic [31:0]        o_centre_speed;
    logic [31:0]        o_angle_speed;

    logic [31:0] mx1_reg, mx2_reg, sc1_reg, sc2_reg, base_reg;
    logic        in_mm_reg;

    t_speed_set expected_speeds[$];
    int  mismatches = 0;
    int  stall_cycles = 0;
    bit  no_gaps = 1'b0;

    mirror_speed_propagation i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(logic [31:0] v);
        return v[31] ? (ONE_FRAC - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic logic [127:0] full_drive(logic [31:0] mx, logic [31:0] sc);
        return 128'(magnitude(mx)) * 128'(magnitude(sc)) * 128'd1000;
    endfunction

    function automatic logic [63:0] ratio(logic [127:0] num, logic [127:0] den,
                                          inout bit over);
        if (num > den) begin
            over = 1'b1;
            return ONE_FRAC;
        end
        if (num == den) return ONE_FRAC;
        return 64'((num << 32) / den);
    endfunction

    function automatic logic [63:0] drive_of(logic [63:0] mmag, logic [31:0] sc);
        logic [63:0] prod, q, low;
        logic [127:0] v;
        prod = mmag * magnitude(sc);
        q = prod >> FRAC;
        low = prod & ((64'd1 << FRAC) - 1);
        if (q >= ONE_FRAC) return ALL_ONES;
        v = 128'd1000 * q + ((128'd1000 * low) >> FRAC);
        return (v > ALL_ONES) ? ALL_ONES : v[63:0];
    endfunction

    function automatic t_speed_set predict_speeds(logic [2:0] kind, logic [31:0] req);
        t_speed_set r;
        bit fail;
        logic [63:0] frac, m1, m2, d1, d2, sum, kmag, factor, q, rem, ang, rmag;
        logic [127:0] da, db;
        r = '0;
        fail = 1'b0;
        frac = ONE_FRAC;
        if (mx1_reg == 0 || mx2_reg == 0 || sc1_reg == 0 || sc2_reg == 0 ||
            base_reg == 0 || kind > msp_pkg::KIND_ANGLE) begin
            r.status = msp_pkg::ST_REJECT;
            return r;
        end
        rmag = magnitude(req);
        kmag = magnitude(base_reg);
        factor = in_mm_reg ? 64'd1000 : 64'd1;
        da = full_drive(mx1_reg, sc1_reg);
        db = full_drive(mx2_reg, sc2_reg);
        if (kind == msp_pkg::KIND_MOTOR1 || kind == msp_pkg::KIND_MOTOR2) begin
            if (req != 0)
                frac = ratio(128'(rmag),
                             128'(magnitude(kind == msp_pkg::KIND_MOTOR1 ? mx1_reg
                                                                         : mx2_reg)),
                             fail);
        end else if (req[31]) begin
            fail = 1'b1;
        end else if (req != 0) begin
            case (kind)
                msp_pkg::KIND_DRIVE1: frac = ratio(128'(rmag) << FRAC, da, fail);
                msp_pkg::KIND_DRIVE2: frac = ratio(128'(rmag) << FRAC, db, fail);
                msp_pkg::KIND_CENTRE: frac = ratio(128'(rmag) << (FRAC + 1), da + db, fail);
                default:     frac = ratio(128'(rmag) * 128'(kmag),
                                          (da + db) * 128'(factor), fail);
            endcase
        end
        m1 = 64'((128'(frac) * 128'(magnitude(mx1_reg))) >> 32);
        m2 = 64'((128'(frac) * 128'(magnitude(mx2_reg))) >> 32);
        d1 = drive_of(m1, sc1_reg);
        d2 = drive_of(m2, sc2_reg);
        sum = d1 + d2;
        q = (factor * sum) / kmag;
        rem = (factor * sum) % kmag;
        if (q >= (64'd1 << (32 - FRAC))) begin
            ang = ALL_ONES;
        end else begin
            ang = (q << FRAC) + ((rem << FRAC) / kmag);
            if (ang > ALL_ONES) ang = ALL_ONES;
        end
        r.status = fail ? msp_pkg::ST_FALLBACK : msp_pkg::ST_OK;
        r.m1 = mx1_reg[31] ? 32'(ONE_FRAC - m1) : m1[31:0];
        r.m2 = mx2_reg[31] ? 32'(ONE_FRAC - m2) : m2[31:0];
        r.d1 = d1[31:0];
        r.d2 = d2[31:0];
        r.centre = 32'(sum >> 1);
        r.angle = ang[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_speed_set want;
        if (i_rst_n && ((i_start && !o_busy) || o_valid)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_speeds.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_status), 32'd0);
            end else begin
                want = expected_speeds.pop_front();
                if (o_status != want.status) report_mismatch("status", 32'(o_status),
                                                             32'(want.status));
                if (o_motor1_speed != want.m1) report_mismatch("motor1", o_motor1_speed,
                                                               want.m1);
                if (o_motor2_speed != want.m2) report_mismatch("motor2", o_motor2_speed,
                                                               want.m2);
                if (o_drive1_speed != want.d1) report_mismatch("drive1", o_drive1_speed,
                                                               want.d1);
                if (o_drive2_speed != want.d2) report_mismatch("drive2", o_drive2_speed,
                                                               want.d2);
                if (o_centre_speed != want.centre) report_mismatch("centre",
                                                   o_centre_speed, want.centre);
                if (o_angle_speed != want.angle) report_mismatch("angle", o_angle_speed,
                                                                 want.angle);
            end
        end
    end

    task automatic send_request(logic [2:0] kind, logic [31:0] req);
        if (!no_gaps && $urandom_range(0, 9) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= kind;
        i_requested_speed <= req;
        @(posedge i_clk iff !o_busy);
        expected_speeds.push_back(predict_speeds(kind, req));
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_speeds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [31:0] mx1, logic [31:0] mx2, logic [31:0] sc1,
                                  logic [31:0] sc2, logic [31:0] base, logic in_mm);
        logic [31:0] vals[6];
        logic [2:0] idx[6];
        vals = '{mx1, mx2, sc1, sc2, base, {31'd0, in_mm}};
        idx = '{msp_pkg::REG_MOTOR1_MAX, msp_pkg::REG_MOTOR2_MAX, msp_pkg::REG_DRIVE1_SC,
                msp_pkg::REG_DRIVE2_SC, msp_pkg::REG_BASE_LEN, msp_pkg::REG_BASE_IN_MM};
        drain_results();
        for (int k = 0; k < 6; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_wr_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        mx1_reg = mx1;
        mx2_reg = mx2;
        sc1_reg = sc1;
        sc2_reg = sc2;
        base_reg = base;
        in_mm_reg = in_mm;
    endtask

    function automatic logic [31:0] random_speed();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000);
            2: return -$urandom_range(0, 32'h0004_0000);
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_setting();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(1, 32'h0004_0000);
            2: return -$urandom_range(1, 32'h0004_0000);
            3: return $urandom >> $urandom_range(8, 31);
            default: return $urandom_range(32'h0000_4000, 32'h0002_0000);
        endcase
    endfunction

    task automatic test_directed_requests();
        logic [31:0] reqs[6];
        reqs = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000};
        for (int k = 0; k < 8; k++)
            for (int n = 0; n < 3; n++)
                send_request(3'(k), reqs[(k + n * 2) % 6]);
        send_request(msp_pkg::KIND_DRIVE1, 32'h0000_1000);
    endtask

    task automatic test_setting_extremes();
        write_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0000_0001, 1'b1);
        for (int k = 0; k < 20; k++) send_request(3'($urandom_range(0, 7)), random_speed());
        write_settings(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                       32'h8000_0000, 1'b0);
        for (int k = 0; k < 20; k++) send_request(3'($urandom_range(0, 7)), random_speed());
        write_settings(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000,
                       32'h0001_0000, 1'b0);
        for (int k = 0; k < 10; k++) send_request(3'($urandom_range(0, 7)), random_speed());
        write_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       32'h0000_0000, 1'b1);
        for (int k = 0; k < 10; k++) send_request(3'($urandom_range(0, 7)), random_speed());
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 13; phase++) begin
            if (phase == 12) no_gaps = 1'b1;
            write_settings(random_setting(), random_setting(), random_setting(),
                           random_setting(), random_setting(), 1'($urandom));
            for (int k = 0; k < 100; k++)
                send_request(3'($urandom_range(0, 15) == 0 ? $urandom_range(6, 7)
                                                           : $urandom_range(0, 5)),
                             random_speed());
        end
    endtask

    initial begin
        mx1_reg = 32'h0001_0000;
        mx2_reg = 32'h0001_0000;
        sc1_reg = 32'h0001_0000;
        sc2_reg = 32'h0001_0000;
        base_reg = 32'h0001_0000;
        in_mm_reg = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_requests();
        test_setting_extremes();
        test_random_settings();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/msp_pkg.sv
rtl/core/msp_front.sv
rtl/core/msp_queue.sv
rtl/core/msp_back.sv
rtl/core/mirror_speed_propagation.sv
bench/mirror_speed_propagation_test.sv
